[design/pit_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants for the timer-divisor square-wave synthesiser.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Payload widths
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned VOLUME_W  = 7;

  // Shared divider geometry: dividend and divisor widths, one step per bit
  localparam int unsigned DVD_W     = 22;
  localparam int unsigned DSR_W     = 16;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  // Twice the timer input clock: numerator of the phase step
  localparam logic [DVD_W-1:0] TIMER_STEP_NUM = 22'd2386364;
  // Full-scale amplitude and the combined scale-down of /127 then /256
  localparam logic [DVD_W-1:0] AMP_FULL = 22'd30000;
  localparam logic [DSR_W-1:0] AMP_DIV  = 16'd32512;

  localparam logic [SAMPLE_W-1:0] SILENCE   = 8'd128;
  localparam logic [VOLUME_W-1:0] VOL_RESET = 7'd127;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WRAP,
    ST_AMP,
    ST_DONE
  } pit_state_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

[design/pit_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_req_if
// Request channel carrying one timer divisor per sample slot.
// ----------------------------------------------------------------------------
interface pit_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface
`default_nettype wire

[design/pit_smp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_smp_if
// Result channel carrying one unsigned 8-bit PCM sample.
// ----------------------------------------------------------------------------
interface pit_smp_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

[design/pit_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_cfg_if
// Configuration write channel for the volume register.
// ----------------------------------------------------------------------------
interface pit_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] volume;

  modport source (output valid, output volume, input ready);
  modport sink   (input valid, input volume, output ready);
endinterface
`default_nettype wire

[design/pit_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_div
// Shared restoring divider: one quotient bit per cycle, quotient and
// remainder held after the done pulse until the next start.
// ----------------------------------------------------------------------------
module pit_div
  import pit_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o,
  output logic      [DSR_W-1:0] remainder_o,
  output div_sts_t              sts_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, dvd_q[DVD_W-1]} - {1'b0, dsr_q};

  // Next value: load on start, else shift one quotient bit in
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      if (!trial[DSR_W]) begin
        rem_d = trial[DSR_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DSR_W-2:0], dvd_q[DVD_W-1]};
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // Hold the step count and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign sts_o.busy  = (cnt_q != '0);
  assign sts_o.done  = done_q;

endmodule
`default_nettype wire

[design/pit_divisor_square_wave_synth.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pit_divisor_square_wave_synth
// Square-wave PCM synthesiser driven by a timer divisor per sample slot.
// ----------------------------------------------------------------------------
// A request with a nonzero divisor gives its sample after three passes of
// one shared 22-step restoring divider (phase step, wrap of the phase
// accumulator against SAMPLE_RATE, amplitude scaling of the volume), after
// which the result is handed to the output register. A zero divisor skips
// the divider, gives silence, and frees the input once that sample is in
// the output register. One request is worked on at a time; the output
// register lets the next request in while a sample waits, and a finished
// sample is held back while the output register is still full. Volume
// writes are taken at any time and act on every request whose amplitude
// scaling has not yet started.
// ----------------------------------------------------------------------------
module pit_divisor_square_wave_synth
  import pit_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE = 22050
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pit_req_if.sink   req_i,
  pit_cfg_if.sink   cfg_i,
  pit_smp_if.source smp_o
);

  localparam int unsigned PHASE_W = $clog2(SAMPLE_RATE);

  pit_state_e state_q, state_d;

  logic [VOLUME_W-1:0] volume_q;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                level_q, level_d;
  logic [SAMPLE_W-1:0] res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_sample_q;

  logic             req_fire;
  logic             out_load;
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quot;
  logic [DSR_W-1:0] div_rem;
  div_sts_t         div_sts;
  logic [DVD_W-1:0] step;
  logic [DVD_W-1:0] phase_sum;
  logic [DVD_W-1:0] vol_scaled;
  logic [SAMPLE_W-1:0] offset;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Phase step never below one; sum with the held phase
  assign step       = (div_quot == '0) ? DVD_W'(1) : div_quot;
  assign phase_sum  = DVD_W'(phase_q) + step;
  assign vol_scaled = DVD_W'(volume_q) * AMP_FULL;
  assign offset     = SAMPLE_W'(div_quot);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.divisor == '0) ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP: if (div_sts.done) state_d = ST_WRAP;
      ST_WRAP: if (div_sts.done) state_d = ST_AMP;
      ST_AMP:  if (div_sts.done) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider operands and start pulses
  always_comb begin
    div_start    = 1'b0;
    div_dividend = TIMER_STEP_NUM;
    div_divisor  = req_i.divisor;
    case (state_q)
      ST_IDLE: begin
        div_start = req_fire && (req_i.divisor != '0);
      end
      ST_STEP: begin
        div_start    = div_sts.done;
        div_dividend = phase_sum;
        div_divisor  = DSR_W'(SAMPLE_RATE);
      end
      ST_WRAP: begin
        div_start    = div_sts.done;
        div_dividend = vol_scaled;
        div_divisor  = AMP_DIV;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Phase, level and result updates
  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.divisor == '0)) begin
          phase_d = '0;
          level_d = 1'b0;
          res_d   = SILENCE;
        end
      end
      ST_WRAP: begin
        if (div_sts.done) begin
          phase_d = div_rem[PHASE_W-1:0];
          level_d = level_q ^ div_quot[0];
        end
      end
      ST_AMP: begin
        if (div_sts.done) begin
          res_d = level_q ? (SILENCE + offset) : (SILENCE - offset);
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Output register: load when empty or being drained
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || smp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (smp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign smp_o.valid  = out_valid_q;
  assign smp_o.sample = out_sample_q;

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      volume_q    <= VOL_RESET;
      phase_q     <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        volume_q <= cfg_i.volume;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_sample_q <= res_q;
    end
  end

  pit_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .sts_o       (div_sts)
  );

  // Divider is quiet whenever a request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !div_sts.busy)
    else $error("divider busy while idle");

  // Phase accumulator stays below the sample rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(phase_q) < SAMPLE_RATE)
    else $error("phase out of range");

  // Divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_STEP || state_q == ST_WRAP || state_q == ST_AMP))
    else $error("unexpected divider done");

  // A loaded sample leaves the sequencer idle next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (smp_o.valid && state_q == ST_IDLE))
    else $error("sample load did not complete");

endmodule
`default_nettype wire
